// ===== hw/rtl/xkfd_pkg.sv =====
// ----------------------------------------------------------------------------
// xkfd_pkg
// Shared types, constants and the keystream text table of the frame
// decryptor.
// ----------------------------------------------------------------------------
package xkfd_pkg;

  // key multiplier applied to the payload size
  localparam logic [31:0] KEY_MULT    = 32'h6765_7268;
  localparam logic [7:0]  MARKER_MIN  = 8'd10;
  localparam logic [7:0]  TABLE_LIMIT = 8'd220;
  localparam logic [15:0] MIN_SIZE    = 16'd7;

  // configuration port
  localparam int unsigned   CFG_ADDR_W  = 3;
  localparam logic [2:0]    CFG_ADDR_V7 = 3'd0;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // validation codes
  localparam logic [1:0] STATUS_PASS       = 2'd0;
  localparam logic [1:0] STATUS_MARKER_POS = 2'd1;
  localparam logic [1:0] STATUS_MARKER_BYTE = 2'd2;
  localparam logic [1:0] STATUS_TABLE      = 2'd3;

  // what the back end does with an item
  typedef enum logic [1:0] {
    ITEM_FIRST,
    ITEM_HEADER,
    ITEM_CHECK,
    ITEM_PAYLOAD
  } item_kind_t;

  // one classified item as it travels through the queue
  typedef struct packed {
    logic [7:0]  data;
    item_kind_t  kind;
    logic [15:0] pidx;
    logic [15:0] size;
    logic [31:0] prod;
    logic        blk_ok;
    logic        last;
  } entry_t;

  // 256-byte keystream text table
  localparam logic [7:0] ROM_TABLE [256] = '{
    8'h41, 8'h73, 8'h20, 8'h70, 8'h61, 8'h72, 8'h74, 8'h20, 8'h6f, 8'h66, 8'h20, 8'h74,
    8'h68, 8'h69, 8'h73, 8'h20, 8'h73, 8'h6f, 8'h66, 8'h74, 8'h77, 8'h61, 8'h72, 8'h65,
    8'h20, 8'h62, 8'h65, 8'h74, 8'h61, 8'h20, 8'h76, 8'h65, 8'h72, 8'h73, 8'h69, 8'h6f,
    8'h6e, 8'h20, 8'h4d, 8'h69, 8'h72, 8'h61, 8'h62, 8'h69, 8'h6c, 8'h69, 8'h73, 8'h20,
    8'h69, 8'h73, 8'h20, 8'h67, 8'h72, 8'h61, 8'h6e, 8'h74, 8'h69, 8'h6e, 8'h67, 8'h20,
    8'h61, 8'h20, 8'h6c, 8'h69, 8'h6d, 8'h69, 8'h74, 8'h65, 8'h64, 8'h20, 8'h61, 8'h63,
    8'h63, 8'h65, 8'h73, 8'h73, 8'h20, 8'h74, 8'h6f, 8'h20, 8'h74, 8'h68, 8'h65, 8'h20,
    8'h49, 8'h43, 8'h51, 8'h20, 8'h6e, 8'h65, 8'h74, 8'h77, 8'h6f, 8'h72, 8'h6b, 8'h2c,
    8'h20, 8'h73, 8'h65, 8'h72, 8'h76, 8'h65, 8'h72, 8'h73, 8'h2c, 8'h20, 8'h64, 8'h69,
    8'h72, 8'h65, 8'h63, 8'h74, 8'h6f, 8'h72, 8'h69, 8'h65, 8'h73, 8'h2c, 8'h20, 8'h6c,
    8'h69, 8'h73, 8'h74, 8'h69, 8'h6e, 8'h67, 8'h73, 8'h2c, 8'h20, 8'h69, 8'h6e, 8'h66,
    8'h6f, 8'h72, 8'h6d, 8'h61, 8'h74, 8'h69, 8'h6f, 8'h6e, 8'h20, 8'h61, 8'h6e, 8'h64,
    8'h20, 8'h64, 8'h61, 8'h74, 8'h61, 8'h62, 8'h61, 8'h73, 8'h65, 8'h73, 8'h20, 8'h28,
    8'h22, 8'h49, 8'h43, 8'h51, 8'h20, 8'h53, 8'h65, 8'h72, 8'h76, 8'h69, 8'h63, 8'h65,
    8'h73, 8'h20, 8'h61, 8'h6e, 8'h64, 8'h20, 8'h49, 8'h6e, 8'h66, 8'h6f, 8'h72, 8'h6d,
    8'h61, 8'h74, 8'h69, 8'h6f, 8'h6e, 8'h22, 8'h29, 8'h2e, 8'h20, 8'h54, 8'h68, 8'h65,
    8'h20, 8'h49, 8'h43, 8'h51, 8'h20, 8'h53, 8'h65, 8'h72, 8'h76, 8'h69, 8'h63, 8'h65,
    8'h20, 8'h61, 8'h6e, 8'h64, 8'h20, 8'h49, 8'h6e, 8'h66, 8'h6f, 8'h72, 8'h6d, 8'h61,
    8'h74, 8'h69, 8'h6f, 8'h6e, 8'h20, 8'h6d, 8'h61, 8'h79, 8'h20, 8'h64, 8'h61, 8'h74,
    8'h61, 8'h62, 8'h61, 8'h73, 8'h65, 8'h73, 8'h20, 8'h28, 8'h22, 8'h49, 8'h43, 8'h51,
    8'h20, 8'h53, 8'h65, 8'h72, 8'h76, 8'h69, 8'h63, 8'h65, 8'h73, 8'h20, 8'h61, 8'h6e,
    8'h64, 8'h20, 8'h49, 8'h6e
  };

  // table lookup
  function automatic logic [7:0] rom_byte(input logic [7:0] idx);
    rom_byte = ROM_TABLE[idx];
  endfunction

endpackage

// ===== hw/rtl/xkfd_front.sv =====
// ----------------------------------------------------------------------------
// xkfd_front
// Tracks the frame position and length, classifies each accepted byte and
// precomputes the size-dependent terms of the key.
// ----------------------------------------------------------------------------
module xkfd_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  v7_framing,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte,
  input  logic                  q_full,
  output logic                  push,
  output xkfd_pkg::entry_t      push_entry
);

  logic [16:0] pos_r, pos_nxt;
  logic [15:0] flen_r, flen_nxt;
  logic [15:0] size_w;
  logic [16:0] pidx_w;
  logic [16:0] blk_lim_w;
  logic        last_w;
  logic [47:0] prod_w;
  xkfd_pkg::item_kind_t kind_w;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // frame length as it stands after this byte
  always_comb begin
    priority if (pos_r == 17'd0) begin
      flen_nxt = {8'd0, in_byte};
    end else if (pos_r == 17'd1) begin
      flen_nxt = {in_byte, flen_r[7:0]};
    end else begin
      flen_nxt = flen_r;
    end
  end

  // payload size and payload index
  always_comb begin
    if (v7_framing && (flen_nxt == 16'd0)) begin
      size_w = 16'd0;
    end else begin
      size_w = flen_nxt - {15'd0, v7_framing};
    end
    pidx_w = pos_r - 17'd2 - {16'd0, v7_framing};
  end

  // classify the byte
  always_comb begin
    priority if (pos_r == 17'd0) begin
      kind_w = xkfd_pkg::ITEM_FIRST;
    end else if (pos_r == 17'd1) begin
      kind_w = xkfd_pkg::ITEM_HEADER;
    end else if (v7_framing && (pos_r == 17'd2)) begin
      kind_w = xkfd_pkg::ITEM_HEADER;
    end else if (pidx_w < 17'd4) begin
      kind_w = xkfd_pkg::ITEM_CHECK;
    end else begin
      kind_w = xkfd_pkg::ITEM_PAYLOAD;
    end
  end

  // frame end and next position
  always_comb begin
    last_w  = (pos_r != 17'd0) && (pos_r == ({1'b0, flen_nxt} + 17'd1));
    pos_nxt = last_w ? 17'd0 : pos_r + 17'd1;
  end

  // keyed block range and size product
  assign blk_lim_w = ({1'b0, size_w} + 17'd3) >> 2;
  assign prod_w    = xkfd_pkg::KEY_MULT * size_w;

  always_comb begin
    push_entry.data   = in_byte;
    push_entry.kind   = kind_w;
    push_entry.pidx   = pidx_w[15:0];
    push_entry.size   = size_w;
    push_entry.prod   = prod_w[31:0];
    push_entry.blk_ok = {1'b0, pidx_w[15:2], 2'b00} < blk_lim_w;
    push_entry.last   = last_w;
  end

  // position and length registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      flen_r <= '0;
    end else if (push) begin
      pos_r  <= pos_nxt;
      flen_r <= flen_nxt;
    end
  end

endmodule

// ===== hw/rtl/xkfd_queue.sv =====
// ----------------------------------------------------------------------------
// xkfd_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module xkfd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  xkfd_pkg::entry_t push_entry,
  input  logic             pop,
  output logic             q_valid,
  output logic             q_full,
  output xkfd_pkg::entry_t head
);

  localparam int unsigned PW = xkfd_pkg::QUEUE_PTR_W;
  localparam int unsigned CW = xkfd_pkg::QUEUE_CNT_W;
  localparam logic [PW-1:0] LAST_PTR = PW'(xkfd_pkg::QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(xkfd_pkg::QUEUE_DEPTH);

  xkfd_pkg::entry_t slots_r [xkfd_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;

  assign q_valid = (count_r != '0);
  assign q_full  = (count_r == FULL_CNT);
  assign head    = slots_r[rd_ptr_r];

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  // item storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== hw/rtl/xkfd_back.sv =====
// ----------------------------------------------------------------------------
// xkfd_back
// Gathers the check word and key, decrypts payload bytes, tracks the marker
// and judges the frame on its last byte; holds the output register.
// ----------------------------------------------------------------------------
module xkfd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  xkfd_pkg::entry_t head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_frame_end,
  output logic [1:0]       out_verify_status
);

  logic [31:0] cw_r, cw_nxt;
  logic [31:0] key_r, key_nxt;
  logic [7:0]  b4_r, b4_nxt;
  logic [7:0]  b6_r, b6_nxt;
  logic [7:0]  mpos_r, mpos_nxt;
  logic [7:0]  mbyte_r, mbyte_nxt;
  logic        mseen_r, mseen_nxt;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        frame_end_r;
  logic [1:0]  status_r;

  logic [31:0] hx_w;
  logic [7:0]  lane_w;
  logic [7:0]  d_w;
  logic [31:0] cw_ins_w;
  logic [7:0]  tix_w;
  logic [1:0]  status_w;

  assign pop               = q_valid && (!out_valid_r || out_ready);
  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_frame_end     = frame_end_r;
  assign out_verify_status = status_r;

  // keystream word for this block and byte lane
  assign hx_w = key_r + {24'd0, xkfd_pkg::rom_byte({head.pidx[7:2], 2'b00})};
  always_comb begin
    unique case (head.pidx[1:0])
      2'd0: lane_w = hx_w[7:0];
      2'd1: lane_w = hx_w[15:8];
      2'd2: lane_w = hx_w[23:16];
      default: lane_w = hx_w[31:24];
    endcase
  end

  always_comb begin
    if ((head.kind == xkfd_pkg::ITEM_PAYLOAD) && head.blk_ok) begin
      d_w = head.data ^ lane_w;
    end else begin
      d_w = head.data;
    end
  end

  // check word byte insert
  always_comb begin
    unique case (head.pidx[1:0])
      2'd0: cw_ins_w = {cw_r[31:8], cw_r[7:0] | head.data};
      2'd1: cw_ins_w = {cw_r[31:16], cw_r[15:8] | head.data, cw_r[7:0]};
      2'd2: cw_ins_w = {cw_r[31:24], cw_r[23:16] | head.data, cw_r[15:0]};
      default: cw_ins_w = {cw_r[31:24] | head.data, cw_r[23:0]};
    endcase
  end

  // frame state update
  always_comb begin
    cw_nxt    = cw_r;
    key_nxt   = key_r;
    b4_nxt    = b4_r;
    b6_nxt    = b6_r;
    mpos_nxt  = mpos_r;
    mbyte_nxt = mbyte_r;
    mseen_nxt = mseen_r;
    unique case (head.kind)
      xkfd_pkg::ITEM_FIRST: begin
        cw_nxt    = '0;
        key_nxt   = '0;
        b4_nxt    = '0;
        b6_nxt    = '0;
        mpos_nxt  = '0;
        mbyte_nxt = '0;
        mseen_nxt = 1'b0;
      end
      xkfd_pkg::ITEM_CHECK: begin
        cw_nxt = cw_ins_w;
        if (head.pidx[1:0] == 2'd3) begin
          key_nxt = head.prod + cw_ins_w;
        end
      end
      xkfd_pkg::ITEM_PAYLOAD: begin
        if (head.pidx == 16'd4) begin
          b4_nxt   = d_w;
          mpos_nxt = d_w ^ cw_r[31:24];
        end
        if (head.pidx == 16'd6) begin
          b6_nxt = d_w;
        end
        if ((head.pidx > 16'd4) && (head.pidx == {8'd0, mpos_r})) begin
          mbyte_nxt = d_w;
          mseen_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // frame validation on the final byte
  assign tix_w = b4_nxt ^ cw_nxt[15:8];
  always_comb begin
    priority if ((head.size < xkfd_pkg::MIN_SIZE) || !mseen_nxt ||
                 (mpos_nxt < xkfd_pkg::MARKER_MIN) ||
                 ({8'd0, mpos_nxt} >= head.size)) begin
      status_w = xkfd_pkg::STATUS_MARKER_POS;
    end else if ((b6_nxt ^ cw_nxt[23:16]) != (mbyte_nxt ^ 8'hFF)) begin
      status_w = xkfd_pkg::STATUS_MARKER_BYTE;
    end else if ((tix_w < xkfd_pkg::TABLE_LIMIT) &&
                 ((b6_nxt ^ cw_nxt[7:0]) != (xkfd_pkg::rom_byte(tix_w) ^ 8'hFF))) begin
      status_w = xkfd_pkg::STATUS_TABLE;
    end else begin
      status_w = xkfd_pkg::STATUS_PASS;
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r    <= '0;
      key_r   <= '0;
      b4_r    <= '0;
      b6_r    <= '0;
      mpos_r  <= '0;
      mbyte_r <= '0;
      mseen_r <= 1'b0;
    end else if (pop) begin
      cw_r    <= cw_nxt;
      key_r   <= key_nxt;
      b4_r    <= b4_nxt;
      b6_r    <= b6_nxt;
      mpos_r  <= mpos_nxt;
      mbyte_r <= mbyte_nxt;
      mseen_r <= mseen_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte_r  <= d_w;
      frame_end_r <= head.last;
      status_r    <= head.last ? status_w : xkfd_pkg::STATUS_PASS;
    end
  end

`ifndef SYNTHESIS
  // status is only reported on the final byte
  a_status_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !frame_end_r |-> status_r == xkfd_pkg::STATUS_PASS)
    else $error("verify status set on a byte that does not end the frame");

  // a frame start clears the marker
  a_first_clears: assert property (@(posedge clk) disable iff (!rst_n)
    pop && (head.kind == xkfd_pkg::ITEM_FIRST) |=> !mseen_r)
    else $error("marker flag survived a frame start");

  // the marker is only captured from a payload item
  a_marker_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(mseen_r) |-> $past(pop && (head.kind == xkfd_pkg::ITEM_PAYLOAD)))
    else $error("marker captured outside a payload item");

  // output register only loads when free or drained
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !pop)
    else $error("output register overwritten while held");
`endif

endmodule

// ===== hw/rtl/xor_keystream_frame_decrypt_core.sv =====
// path: an accepted item is written into a queue slot and then loaded into the
//   output register once that register is free or drained
// throughput: one item per cycle unless q_full or out_ready stalls it; front
//   position counter, queue and back key/marker registers step once per item
// reset: rst_n synchronous active low, clears position, queue, output valid
//   and sets v7 framing to 1; no clearing pass
// ----------------------------------------------------------------------------
// xor_keystream_frame_decrypt_core
// Byte-stream frame decryptor: front classifier, item queue and back end
// that decrypts and validates, with an APB-style configuration register.
// ----------------------------------------------------------------------------
module xor_keystream_frame_decrypt_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_byte,
  output logic                          out_frame_end,
  output logic [1:0]                    out_verify_status,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [xkfd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic             v7_r;
  logic             push;
  logic             pop;
  logic             q_valid;
  logic             q_full;
  xkfd_pkg::entry_t push_entry;
  xkfd_pkg::entry_t head;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == xkfd_pkg::CFG_ADDR_V7) ? {31'd0, v7_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b1;
    end else if (psel && penable && pwrite && (paddr == xkfd_pkg::CFG_ADDR_V7)) begin
      v7_r <= pwdata[0];
    end
  end

  // front: position tracking and classification
  xkfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .v7_framing (v7_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // item queue
  xkfd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_full     (q_full),
    .head       (head)
  );

  // back: decrypt and validate
  xkfd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .head              (head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_frame_end     (out_frame_end),
    .out_verify_status (out_verify_status)
  );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keyed XOR frame decryptor. A directed table
// covers empty and short frames, both framings and a framing change inside a
// frame. Random frames follow, most of them built to pass or to fail exactly
// one validation step. Each result is checked against its directed row or an
// in-bench model of the decryptor, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DIRECTED_ITEMS = 23;
  localparam int RANDOM_ITEMS   = 370;
  localparam int MAX_PRINTS     = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       fend;
    logic [1:0] status;
  } frame_out_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] value;
    logic       typed;
    frame_out_t want;
  } dir_row_t;

  typedef enum logic [2:0] {
    FRAME_CLEAN,
    FRAME_BAD_MARKER_BYTE,
    FRAME_BAD_TABLE,
    FRAME_BAD_POS,
    FRAME_NOISE
  } frame_kind_t;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_LIGHT, IDLE_FULL} idle_mode_t;

  // directed frames, starting from v7 framing after reset
  localparam dir_row_t DIR_ROWS [25] = '{
    // v7 with zero length: just the two length bytes
    '{ROW_BYTE, 8'h00, 1'b1, '{8'h00, 1'b0, xkfd_pkg::STATUS_PASS}},
    '{ROW_BYTE, 8'h00, 1'b1, '{8'h00, 1'b1, xkfd_pkg::STATUS_MARKER_POS}},
    // v7 with length one: start byte only, empty payload
    '{ROW_BYTE, 8'h01, 1'b1, '{8'h01, 1'b0, xkfd_pkg::STATUS_PASS}},
    '{ROW_BYTE, 8'h00, 1'b1, '{8'h00, 1'b0, xkfd_pkg::STATUS_PASS}},
    '{ROW_BYTE, 8'hAA, 1'b1, '{8'hAA, 1'b1, xkfd_pkg::STATUS_MARKER_POS}},
    '{ROW_CFG,  8'h00, 1'b0, '{8'h00, 1'b0, xkfd_pkg::STATUS_PASS}},
    // v6 short payload, nothing keyed
    '{ROW_BYTE, 8'h06, 1'b1, '{8'h06, 1'b0, xkfd_pkg::STATUS_PASS}},
    '{ROW_BYTE, 8'h00, 1'b1, '{8'h00, 1'b0, xkfd_pkg::STATUS_PASS}},
    '{ROW_BYTE, 8'hFF, 1'b1, '{8'hFF, 1'b0, xkfd_pkg::STATUS_PASS}},
    '{ROW_BYTE, 8'hFF, 1'b1, '{8'hFF, 1'b0, xkfd_pkg::STATUS_PASS}},
    '{ROW_BYTE, 8'hFF, 1'b1, '{8'hFF, 1'b0, xkfd_pkg::STATUS_PASS}},
    '{ROW_BYTE, 8'hFF, 1'b1, '{8'hFF, 1'b0, xkfd_pkg::STATUS_PASS}},
    '{ROW_BYTE, 8'h00, 1'b1, '{8'h00, 1'b0, xkfd_pkg::STATUS_PASS}},
    '{ROW_BYTE, 8'hFF, 1'b1, '{8'hFF, 1'b1, xkfd_pkg::STATUS_MARKER_POS}},
    // framing switched to v7 between the length and the payload
    '{ROW_BYTE, 8'h08, 1'b0, '{8'h00, 1'b0, xkfd_pkg::STATUS_PASS}},
    '{ROW_BYTE, 8'h00, 1'b0, '{8'h00, 1'b0, xkfd_pkg::STATUS_PASS}},
    '{ROW_CFG,  8'h01, 1'b0, '{8'h00, 1'b0, xkfd_pkg::STATUS_PASS}},
    '{ROW_BYTE, 8'h5A, 1'b0, '{8'h00, 1'b0, xkfd_pkg::STATUS_PASS}},
    '{ROW_BYTE, 8'h12, 1'b0, '{8'h00, 1'b0, xkfd_pkg::STATUS_PASS}},
    '{ROW_BYTE, 8'h34, 1'b0, '{8'h00, 1'b0, xkfd_pkg::STATUS_PASS}},
    '{ROW_BYTE, 8'h56, 1'b0, '{8'h00, 1'b0, xkfd_pkg::STATUS_PASS}},
    '{ROW_BYTE, 8'h0C, 1'b0, '{8'h00, 1'b0, xkfd_pkg::STATUS_PASS}},
    '{ROW_BYTE, 8'hC3, 1'b0, '{8'h00, 1'b0, xkfd_pkg::STATUS_PASS}},
    '{ROW_BYTE, 8'h80, 1'b0, '{8'h00, 1'b0, xkfd_pkg::STATUS_PASS}},
    '{ROW_BYTE, 8'h7F, 1'b0, '{8'h00, 1'b0, xkfd_pkg::STATUS_PASS}}
  };

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic [7:0]                      in_byte;
  logic                            out_valid;
  logic                            out_ready;
  logic [7:0]                      out_byte;
  logic                            out_frame_end;
  logic [1:0]                      out_verify_status;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [xkfd_pkg::CFG_ADDR_W-1:0] paddr;
  logic [31:0]                     pwdata;
  logic [31:0]                     prdata;
  logic                            pready;

  // decryptor model state
  logic        cfg_v7;
  logic [16:0] frame_pos;
  logic [15:0] frame_len;
  logic [31:0] check_word;
  logic [31:0] stream_key;
  logic [7:0]  plain_four;
  logic [7:0]  plain_six;
  logic [7:0]  marker_pos;
  logic [7:0]  marker_byte;
  logic        marker_seen;

  // decrypted bytes still owed by the block, oldest first
  frame_out_t  plain_q[$];
  logic        typed_now;
  frame_out_t  typed_res;

  idle_mode_t  idle_mode;
  int          ready_hold;
  int          quiet_cycles;
  int          errors;
  int          items_sent;
  int          cfg_writes;
  int          frames_done;
  int          status_seen[4];

  xor_keystream_frame_decrypt_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_frame_end     (out_frame_end),
    .out_verify_status (out_verify_status),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    case (idle_mode)
      IDLE_NONE:  pick_gap = 0;
      IDLE_LIGHT: pick_gap = (r < 10) ? 1 : 0;
      default: begin
        if (r < 65)      pick_gap = 0;
        else if (r < 93) pick_gap = $urandom_range(3, 1);
        else             pick_gap = $urandom_range(40, 8);
      end
    endcase
  endfunction

  // payload size as the framing defines it
  function automatic int unsigned payload_len(logic v7);
    if (v7 && frame_len == 16'd0) return 0;
    return 32'(frame_len) - 32'(v7);
  endfunction

  // only the first quarter of the payload is keyed
  function automatic logic keyed(int unsigned p, int unsigned size);
    return (p & ~32'd3) < (size + 32'd3) / 32'd4;
  endfunction

  // keystream byte for payload byte p
  function automatic logic [7:0] key_lane(logic [31:0] k, int unsigned p);
    logic [31:0] h;
    h = k + {24'd0, xkfd_pkg::ROM_TABLE[(p & ~32'd3) & 32'hFF]};
    h = h >> (8 * (p & 32'd3));
    return h[7:0];
  endfunction

  // validation status given on the last frame byte
  function automatic logic [1:0] judge_frame(int unsigned size);
    logic [7:0] x;
    if (size < 7 || !marker_seen || marker_pos < xkfd_pkg::MARKER_MIN ||
        marker_pos >= size)
      return xkfd_pkg::STATUS_MARKER_POS;
    if ((plain_six ^ check_word[23:16]) != (marker_byte ^ 8'hFF))
      return xkfd_pkg::STATUS_MARKER_BYTE;
    x = plain_four ^ check_word[15:8];
    if (x < xkfd_pkg::TABLE_LIMIT &&
        (plain_six ^ check_word[7:0]) != (xkfd_pkg::ROM_TABLE[x] ^ 8'hFF))
      return xkfd_pkg::STATUS_TABLE;
    return xkfd_pkg::STATUS_PASS;
  endfunction

  // one raw byte in, one result out; advances the model state
  function automatic void decrypt_byte(logic [7:0] b, output frame_out_t r);
    logic        v7;
    int unsigned p;
    int unsigned size;
    logic [7:0]  d;
    v7 = cfg_v7;
    d = b;
    r = '0;
    if (frame_pos == 17'd0) begin
      frame_len   = {8'd0, b};
      check_word  = '0;
      stream_key  = '0;
      plain_four  = '0;
      plain_six   = '0;
      marker_pos  = '0;
      marker_byte = '0;
      marker_seen = 1'b0;
    end else if (frame_pos == 17'd1) begin
      frame_len[15:8] = b;
    end else if (!(v7 && frame_pos == 17'd2)) begin
      p = 32'(frame_pos) - 32'd2 - 32'(v7);
      size = payload_len(v7);
      if (p < 4) begin
        check_word = check_word | ({24'd0, b} << (8 * p));
        if (p == 3) stream_key = xkfd_pkg::KEY_MULT * size + check_word;
      end else begin
        if (keyed(p, size)) d = b ^ key_lane(stream_key, p);
        if (p == 4) begin
          plain_four = d;
          marker_pos = d ^ check_word[31:24];
        end
        if (p == 6) plain_six = d;
        if (p > 4 && p == 32'(marker_pos)) begin
          marker_byte = d;
          marker_seen = 1'b1;
        end
      end
    end
    r.data = d;
    if (frame_pos != 17'd0 && frame_pos == {1'b0, frame_len} + 17'd1) begin
      r.fend = 1'b1;
      r.status = judge_frame(payload_len(v7));
      frame_pos = '0;
    end else begin
      frame_pos = frame_pos + 17'd1;
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (errors < MAX_PRINTS)
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    errors++;
  endtask

  // model update, result check and watchdog at each rising edge
  always @(posedge clk) begin : monitor
    frame_out_t r;
    if (!rst_n) begin
      cfg_v7       = 1'b1;
      frame_pos    = '0;
      frame_len    = '0;
      check_word   = '0;
      stream_key   = '0;
      plain_four   = '0;
      plain_six    = '0;
      marker_pos   = '0;
      marker_byte  = '0;
      marker_seen  = 1'b0;
      quiet_cycles = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == xkfd_pkg::CFG_ADDR_V7)
        cfg_v7 = pwdata[0];
      if (in_valid && in_ready) begin
        decrypt_byte(in_byte, r);
        plain_q = {plain_q, (typed_now ? typed_res : r)};
      end
      if (out_valid && out_ready) begin
        if (plain_q.size() == 0) begin
          report_mismatch("result with no item pending", out_byte, 0);
        end else begin
          r = plain_q[0];
          plain_q.delete(0);
          if (out_byte !== r.data) report_mismatch("out_byte", out_byte, r.data);
          if (out_frame_end !== r.fend)
            report_mismatch("out_frame_end", out_frame_end, r.fend);
          if (out_verify_status !== r.status)
            report_mismatch("out_verify_status", out_verify_status, r.status);
        end
        if (out_frame_end === 1'b1) begin
          frames_done++;
          status_seen[out_verify_status]++;
        end
      end
      // watchdog on cycles with no traffic at all
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] no traffic for %0d cycles, %0d results pending", $time,
                 WATCHDOG_LIMIT, plain_q.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold = ready_hold - 1;
    end else begin
      out_ready <= 1'b1;
      ready_hold = pick_gap();
    end
  end

  // offer one item and wait until it is taken
  task automatic send_byte(logic [7:0] b, logic typed = 1'b0, frame_out_t want = '0);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    in_byte   = b;
    typed_now = typed;
    typed_res = want;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  // wait for every owed result, then for the pipeline to empty
  task automatic settle();
    in_valid = 1'b0;
    while (plain_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_v7(logic v);
    settle();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = xkfd_pkg::CFG_ADDR_V7;
    pwdata  = {31'd0, v};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    cfg_writes++;
  endtask

  // build a plaintext frame shaped for one validation outcome, key it, send it
  task automatic send_frame(frame_kind_t kind, int unsigned size);
    logic [7:0]  pl[];
    logic [31:0] chk;
    logic [31:0] key;
    logic [15:0] flen;
    logic [7:0]  m;
    logic [7:0]  x;
    logic [7:0]  p6;
    logic [7:0]  mark;
    int unsigned p;
    pl = new[size];
    foreach (pl[i]) pl[i] = 8'($urandom);
    chk = $urandom;
    if (kind == FRAME_BAD_POS && size >= 7) begin
      // marker index below the minimum or past the payload
      if (size > 255 || $urandom_range(1) == 0)
        m = 8'($urandom_range(xkfd_pkg::MARKER_MIN - 1));
      else
        m = 8'($urandom_range(255, size));
      pl[4] = m ^ chk[31:24];
    end else if (kind != FRAME_NOISE && kind != FRAME_BAD_POS && size >= 11) begin
      m = 8'($urandom_range((size > 256) ? 255 : size - 1, xkfd_pkg::MARKER_MIN));
      x = (kind == FRAME_BAD_TABLE) ? 8'($urandom_range(xkfd_pkg::TABLE_LIMIT - 1)) :
                                      8'($urandom);
      pl[4] = m ^ chk[31:24];
      chk[15:8] = pl[4] ^ x;
      p6 = (x < xkfd_pkg::TABLE_LIMIT) ? (xkfd_pkg::ROM_TABLE[x] ^ 8'hFF ^ chk[7:0]) :
                                         pl[6];
      if (kind == FRAME_BAD_TABLE) p6 = p6 ^ 8'($urandom_range(255, 1));
      pl[6] = p6;
      mark = p6 ^ chk[23:16] ^ 8'hFF;
      if (kind == FRAME_BAD_MARKER_BYTE) mark = mark ^ 8'($urandom_range(255, 1));
      pl[m] = mark;
    end
    // key the payload, then lay the check word in front
    key = xkfd_pkg::KEY_MULT * size + chk;
    for (p = 4; p < size; p++)
      if (keyed(p, size)) pl[p] = pl[p] ^ key_lane(key, p);
    for (p = 0; p < 4 && p < size; p++) pl[p] = chk[8*p +: 8];
    flen = 16'(size + 32'(cfg_v7));
    send_byte(flen[7:0]);
    send_byte(flen[15:8]);
    if (cfg_v7) send_byte(8'($urandom));
    foreach (pl[i]) send_byte(pl[i]);
  endtask

  initial begin : stimulus
    int          phase;
    int          r;
    frame_kind_t kind;
    int unsigned size;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_byte    = '0;
    out_ready  = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    typed_now  = 1'b0;
    typed_res  = '0;
    idle_mode  = IDLE_FULL;
    ready_hold = 0;
    errors     = 0;
    items_sent = 0;
    cfg_writes = 0;
    frames_done = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].kind == ROW_CFG) write_v7(DIR_ROWS[i].value[0]);
      else send_byte(DIR_ROWS[i].value, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    end

    // random phases, each under one framing
    phase = 0;
    while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
      idle_mode = ($urandom_range(3) == 0) ? IDLE_NONE :
                  (($urandom_range(3) == 0) ? IDLE_LIGHT : IDLE_FULL);
      write_v7((phase < 2) ? phase[0] : 1'($urandom_range(1)));
      repeat ($urandom_range(8, 3)) begin
        if (items_sent >= DIRECTED_ITEMS + RANDOM_ITEMS) break;
        r = $urandom_range(99);
        if (r < 45)      kind = FRAME_CLEAN;
        else if (r < 60) kind = FRAME_BAD_MARKER_BYTE;
        else if (r < 75) kind = FRAME_BAD_TABLE;
        else if (r < 85) kind = FRAME_BAD_POS;
        else             kind = FRAME_NOISE;
        if (kind >= FRAME_BAD_POS)          size = $urandom_range(40);
        else if ($urandom_range(9) == 0)    size = $urandom_range(120, 49);
        else                                size = $urandom_range(48, 11);
        send_frame(kind, size);
      end
      phase++;
    end

    settle();
    $display("covered %0d items in %0d frames over %0d framing writes", items_sent,
             frames_done, cfg_writes);
    $display("frame status: pass %0d, marker position %0d, marker byte %0d, table %0d",
             status_seen[xkfd_pkg::STATUS_PASS], status_seen[xkfd_pkg::STATUS_MARKER_POS],
             status_seen[xkfd_pkg::STATUS_MARKER_BYTE], status_seen[xkfd_pkg::STATUS_TABLE]);
    if (errors == 0 && plain_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
